>>> rtl/sshf_pkg.sv
// ----------------------------------------------------------------------------
// SPI slave handshake framer package
// Shared codes, state types and the transmit queue interface structs.
// ----------------------------------------------------------------------------
package sshf_pkg;

   localparam int TX_DEPTH_DEF = 32;

   localparam logic [1:0] MODE_EXCHANGE = 2'd0;
   localparam logic [1:0] MODE_DESELECT = 2'd1;
   localparam logic [1:0] MODE_PUSH     = 2'd2;
   localparam logic [1:0] MODE_CLEAR    = 2'd3;

   localparam logic [1:0] CSR_STOP_CODE  = 2'd0;
   localparam logic [1:0] CSR_NO_COMMAND = 2'd1;
   localparam logic [1:0] CSR_INIT_ACK   = 2'd2;

   localparam logic [7:0] SYNC_BYTE = 8'h5A;
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ZERO_BYTE = 8'h00;
   localparam logic [7:0] ONE_BYTE  = 8'h01;

   typedef enum logic [2:0] {
      HS_BEGIN,
      HS_CONFIRM,
      HS_RESPONSE,
      HS_VALIDATE,
      HS_LINKED
   } hs_state_type;

   typedef enum logic [1:0] {
      FP_COMMAND,
      FP_LENGTH,
      FP_DATA,
      FP_CRC
   } frame_pos_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [7:0] data;
   } txq_ctrl_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic [7:0] head_data;
   } txq_status_type;

endpackage

>>> rtl/sshf_tx_queue.sv
// ----------------------------------------------------------------------------
// Transmit queue
// Circular byte queue in a synchronous memory. The word at the head is
// prefetched into a register, with write forwarding, so that a pop sees it
// at once. A push into a full queue drops the oldest word.
// ----------------------------------------------------------------------------
module sshf_tx_queue #(
   parameter int TX_DEPTH = sshf_pkg::TX_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sshf_pkg::txq_ctrl_type   ctrl,
   output sshf_pkg::txq_status_type status
);
   import sshf_pkg::*;

   localparam int HEAD_W = $clog2(TX_DEPTH);
   localparam logic [HEAD_W:0]   DEPTH_C = (HEAD_W + 1)'(TX_DEPTH);
   localparam logic [HEAD_W-1:0] LAST_C  = HEAD_W'(TX_DEPTH - 1);

   logic [7:0]        mem_ff [TX_DEPTH];
   logic [7:0]        head_data_ff;
   logic [HEAD_W-1:0] head_ff, head_in, head_inc, wr_addr;
   logic [HEAD_W:0]   count_ff, count_in, tail_sum, tail_wrap;
   logic              full;

   always_comb begin
      full      = (count_ff == DEPTH_C);
      head_inc  = (head_ff == LAST_C) ? '0 : head_ff + 1'b1;
      tail_sum  = {1'b0, head_ff} + count_ff;
      tail_wrap = (tail_sum >= DEPTH_C) ? tail_sum - DEPTH_C : tail_sum;
      wr_addr   = full ? head_ff : tail_wrap[HEAD_W-1:0];
      head_in   = head_ff;
      count_in  = count_ff;
      if (ctrl.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (ctrl.push) begin
         if (full) begin
            head_in = head_inc;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (ctrl.pop) begin
         head_in  = head_inc;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem_ff[wr_addr] <= ctrl.data;
      end
      if (ctrl.push && (wr_addr == head_in)) begin
         head_data_ff <= ctrl.data;
      end else begin
         head_data_ff <= mem_ff[head_in];
      end
   end

   assign status.empty     = (count_ff == '0);
   assign status.full      = full;
   assign status.head_data = head_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("transmit queue count exceeds depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> count_ff != '0)
      else $error("pop from empty transmit queue");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> count_ff == '0 && head_ff == '0)
      else $error("clear did not empty the transmit queue");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.push && full |=> count_ff == DEPTH_C && head_ff == $past(head_inc))
      else $error("overflow push did not drop the oldest word");

endmodule

>>> rtl/spi_slave_handshake_framer_unit.sv
// ----------------------------------------------------------------------------
// SPI slave handshake framer
// Runs the link handshake per received byte, loads the next transmit byte and
// marks received bytes as command, length, data or CRC of a frame.
// ----------------------------------------------------------------------------
// A result word is registered and valid in the cycle after its request word
// is taken. Throughput: one word per cycle while rsp_tready is high or no
// result is held; the queue head is prefetched from its memory into a
// register, so a pop sees it at once. Reset is synchronous and clears the
// handshake, frame state, queue pointers and CSR registers; the queue memory
// is not cleared, its entries are read only after they have been written.
// ----------------------------------------------------------------------------
module spi_slave_handshake_framer_unit #(
   parameter int TX_DEPTH = sshf_pkg::TX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_byte[7:0], link_ready[8], host_acked[9], receive_hold[10]
   input  logic [15:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tx_byte[7:0], rx_push[8], rx_data[16:9], link_up[17], tx_overflow[18]
   output logic [23:0] rsp_tdata,
   // frame_field[1:0]
   output logic [1:0]  rsp_tuser
);
   import sshf_pkg::*;

   logic [7:0]     stop_ff, no_cmd_ff, init_ack_ff;
   hs_state_type   hs_ff, hs_in;
   frame_pos_type  pos_ff, pos_in, field;
   logic [7:0]     left_ff, left_in, shift_ff, shift_in;
   logic           rsp_valid_ff;
   logic [23:0]    rsp_data_ff;
   logic [1:0]     rsp_user_ff;
   logic           req_accept, rx_push, do_push, do_pop, do_clear, cmd_allowed;
   logic [1:0]     mode;
   logic [7:0]     data_byte;
   logic           link_ready, host_acked, receive_hold;
   txq_ctrl_type   txq_ctrl;
   txq_status_type txq_status;

   assign mode         = req_tuser;
   assign data_byte    = req_tdata[7:0];
   assign link_ready   = req_tdata[8];
   assign host_acked   = req_tdata[9];
   assign receive_hold = req_tdata[10];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff     <= '0;
         no_cmd_ff   <= '0;
         init_ack_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STOP_CODE:  stop_ff     <= csr_wdata;
            CSR_NO_COMMAND: no_cmd_ff   <= csr_wdata;
            CSR_INIT_ACK:   init_ack_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      hs_in = hs_ff;
      if (mode == MODE_DESELECT) begin
         hs_in = HS_BEGIN;
      end else if (mode == MODE_EXCHANGE && link_ready) begin
         case (hs_ff)
            HS_BEGIN:    hs_in = (data_byte == ZERO_BYTE) ? HS_CONFIRM : HS_BEGIN;
            HS_CONFIRM:  hs_in = (data_byte == ZERO_BYTE) ? HS_RESPONSE : HS_BEGIN;
            HS_RESPONSE: hs_in = (data_byte == SYNC_BYTE) ? HS_VALIDATE : HS_BEGIN;
            HS_VALIDATE: hs_in = ($countones(data_byte) > 2) ? HS_LINKED : HS_BEGIN;
            default:     hs_in = HS_LINKED;
         endcase
      end
   end

   always_comb begin
      shift_in    = shift_ff;
      pos_in      = pos_ff;
      left_in     = left_ff;
      rx_push     = 1'b0;
      field       = FP_COMMAND;
      do_push     = 1'b0;
      do_pop      = 1'b0;
      do_clear    = 1'b0;
      cmd_allowed = host_acked || pos_ff != FP_COMMAND || data_byte == init_ack_ff;
      case (mode)
         MODE_EXCHANGE: begin
            if (!link_ready) begin
               shift_in = stop_ff;
            end else begin
               case (hs_ff)
                  HS_BEGIN: begin
                     if (data_byte == ZERO_BYTE) shift_in = SYNC_BYTE;
                  end
                  HS_CONFIRM: begin
                     shift_in = (data_byte == ZERO_BYTE) ? FLAG_BYTE : ZERO_BYTE;
                  end
                  HS_RESPONSE: begin
                     shift_in = (data_byte == SYNC_BYTE) ? FLAG_BYTE : ZERO_BYTE;
                  end
                  HS_VALIDATE: begin
                     shift_in = ZERO_BYTE;
                  end
                  default: ;
               endcase
               if (hs_in == HS_LINKED) begin
                  if (!txq_status.empty) begin
                     do_pop   = 1'b1;
                     shift_in = txq_status.head_data;
                  end else begin
                     shift_in = stop_ff;
                  end
                  if (cmd_allowed && !receive_hold) begin
                     case (pos_ff)
                        FP_COMMAND: begin
                           if (data_byte != no_cmd_ff && data_byte != FLAG_BYTE) begin
                              rx_push = 1'b1;
                              field   = FP_COMMAND;
                              pos_in  = FP_LENGTH;
                           end
                        end
                        FP_LENGTH: begin
                           rx_push = 1'b1;
                           field   = FP_LENGTH;
                           left_in = data_byte;
                           pos_in  = (data_byte == ZERO_BYTE) ? FP_CRC : FP_DATA;
                        end
                        FP_DATA: begin
                           rx_push = 1'b1;
                           field   = FP_DATA;
                           left_in = left_ff - ONE_BYTE;
                           if (left_ff == ONE_BYTE) pos_in = FP_CRC;
                        end
                        default: begin
                           rx_push = 1'b1;
                           field   = FP_CRC;
                           pos_in  = FP_COMMAND;
                        end
                     endcase
                  end
               end
            end
         end
         MODE_DESELECT: shift_in = stop_ff;
         MODE_PUSH:     do_push  = 1'b1;
         MODE_CLEAR:    do_clear = 1'b1;
         default: ;
      endcase
   end

   assign txq_ctrl.push  = req_accept && do_push;
   assign txq_ctrl.pop   = req_accept && do_pop;
   assign txq_ctrl.clear = req_accept && do_clear;
   assign txq_ctrl.data  = data_byte;

   sshf_tx_queue #(
      .TX_DEPTH(TX_DEPTH)
   ) u_tx_queue (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (txq_ctrl),
      .status (txq_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff        <= HS_BEGIN;
         pos_ff       <= FP_COMMAND;
         left_ff      <= '0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            hs_ff        <= hs_in;
            pos_ff       <= pos_in;
            left_ff      <= left_in;
            shift_ff     <= shift_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= {5'b0, do_push && txq_status.full, hs_in == HS_LINKED,
                         rx_push ? data_byte : ZERO_BYTE, rx_push, shift_in};
         rsp_user_ff <= rx_push ? field : FP_COMMAND;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_push_needs_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[8] |-> rsp_data_ff[17])
      else $error("received word framed without link");

   a_idle_field_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[8] |-> rsp_user_ff == FP_COMMAND
                                          && rsp_data_ff[16:9] == ZERO_BYTE)
      else $error("unframed word carries frame data");

   a_not_ready_freeze: assert property (@(posedge clock) disable iff (reset)
      req_accept && mode == MODE_EXCHANGE && !link_ready
      |=> $stable(hs_ff) && $stable(pos_ff) && $stable(left_ff))
      else $error("link not ready changed handshake or frame state");

   a_deselect_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && mode == MODE_DESELECT |=> hs_ff == HS_BEGIN && shift_ff == stop_ff)
      else $error("deselect did not restart the handshake");

endmodule
